>>> sv/pbts_pkg.sv
// Package for the priority bitmap task scheduler.
// Holds default sizes, field widths, action codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pbts_pkg;

  // Default sizes of the task table and of the level table.
  localparam int TASK_COUNT_DEF  = 32;
  localparam int LEVEL_COUNT_DEF = 32;

  // Fixed field widths of the stream items.
  localparam int ID_W      = 5;
  localparam int LVL_W     = 5;
  localparam int TMO_W     = 32;
  localparam int TICK_W    = 10;
  localparam int IDLE_W    = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // Register index of the tick register.
  localparam logic REG_TICK = 1'b0;
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

  typedef enum logic [1:0] {
    ACT_PICK  = 2'd0,
    ACT_READY = 2'd1,
    ACT_BLOCK = 2'd2,
    ACT_FREE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PK_H,
    ST_TK,
    ST_RM_P,
    ST_RM_PW,
    ST_RM_N,
    ST_RM_NW,
    ST_AP,
    ST_AP_L,
    ST_AP_TW,
    ST_AP_T,
    ST_OUT
  } state_e;

endpackage

>>> sv/pbts_ram.sv
// Generic single-port RAM with registered read data.
// Used for the task link table and the level head/tail table. No dependencies.
`timescale 1ns / 1ps

module pbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on request; read data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sv/priority_bitmap_task_scheduler_core.sv
// Top level of the priority bitmap task scheduler.
// Depends on pbts_pkg and pbts_ram (task link table, level head/tail table).
`timescale 1ns / 1ps

// Usage:
// Requests enter on the s_axis channel: one action (pick, make ready, make
// blocked, make free) per request. Each request gives exactly one result on
// the m_axis channel: the picked task, the idle flag and the idle time.
// The tick register sets how many milliseconds an idle pick adds.
// One request is worked on at a time by a sequencer that reads, modifies and
// writes back two single-port RAMs, one access per RAM per cycle, with
// registered read data. Each neighbor link update is a read state followed
// by a write state. A finished result sits in an output register; the next
// request is taken while it waits. If the receiver stalls, the sequencer
// holds at its last step until the output register is free.
// Reset empties all levels and clears the idle time; the RAMs are not
// cleared, since a task entry is only read while its ready flop is set and a
// level entry only while its level bit is set.
module priority_bitmap_task_scheduler_core #(
  parameter int TASK_COUNT  = pbts_pkg::TASK_COUNT_DEF,
  parameter int LEVEL_COUNT = pbts_pkg::LEVEL_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: action[2], task_id[5], level[5], base_level[5],
  // waits_on_object[1], timeout_ms[32], zero fill[6].
  input  logic [pbts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: next_task[5], idle_selected[1], idle_time[32],
  // zero fill[2].
  output logic [pbts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TIW = $clog2(TASK_COUNT);
  localparam int IDW = $clog2(TASK_COUNT + 1);
  localparam int LW  = $clog2(LEVEL_COUNT);
  localparam int TW  = 2 * IDW + LW;
  localparam int LWW = 2 * IDW;
  localparam logic [IDW-1:0] NIL = IDW'(TASK_COUNT);

  // Request fields.
  logic [1:0]  in_action;
  logic [4:0]  in_task;
  logic [4:0]  in_level;
  logic [LW-1:0] in_lv_sat;
  logic        in_task_ok;

  assign in_action = s_axis_tdata[1:0];
  assign in_task   = s_axis_tdata[6:2];
  assign in_level  = s_axis_tdata[11:7];
  assign in_lv_sat = (int'(in_level) >= LEVEL_COUNT) ? LW'(LEVEL_COUNT - 1) : LW'(in_level);
  assign in_task_ok = int'(in_task) < TASK_COUNT;

  // Control and working registers.
  pbts_pkg::state_e state_q, state_d;
  logic [LEVEL_COUNT-1:0] ready_lv_q, ready_lv_d;
  logic [TASK_COUNT-1:0]  ready_task_q, ready_task_d;
  logic [pbts_pkg::TICK_W-1:0] tick_q;
  logic [31:0] idle_q, idle_d;
  logic [1:0]  action_q, action_d;
  logic [IDW-1:0] t_q, t_d, p_q, p_d, n_q, n_d, tl_q, tl_d;
  logic [LW-1:0]  lv_q, lv_d, rlv_q, rlv_d;
  logic do_app_q, do_app_d, found_q, found_d;
  logic out_valid_q, out_valid_d;
  logic [4:0]  out_task_q, out_task_d;
  logic        out_idle_q, out_idle_d;
  logic [31:0] out_time_q, out_time_d;

  // RAM ports.
  logic [TIW-1:0] task_addr;
  logic           task_we;
  logic [TW-1:0]  task_wdata, task_rdata;
  logic [LW-1:0]  lvl_addr;
  logic           lvl_we;
  logic [LWW-1:0] lvl_wdata, lvl_rdata;

  logic [IDW-1:0] tr_next, tr_prev, lr_head, lr_tail, tl_now;
  logic [LW-1:0]  tr_lvl;
  logic [LW-1:0]  top_lv;
  logic [32:0]    idle_sum;
  logic           out_free;

  assign tr_next = task_rdata[TW-1 -: IDW];
  assign tr_prev = task_rdata[LW +: IDW];
  assign tr_lvl  = task_rdata[LW-1:0];
  assign lr_head = lvl_rdata[LWW-1 -: IDW];
  assign lr_tail = lvl_rdata[IDW-1:0];
  assign tl_now  = ready_lv_q[lv_q] ? lr_tail : NIL;
  assign idle_sum = {1'b0, idle_q} + 33'(tick_q);
  assign out_free = !out_valid_q || m_axis_tready;

  // Most urgent non-empty level: lowest index with its bit set.
  always_comb begin
    top_lv = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (ready_lv_q[i]) begin
        top_lv = LW'(i);
      end
    end
  end

  pbts_ram #(.WIDTH(TW), .DEPTH(TASK_COUNT)) u_task_ram (
    .clk_i   (clk_i),
    .addr_i  (task_addr),
    .we_i    (task_we),
    .wdata_i (task_wdata),
    .rdata_o (task_rdata)
  );

  pbts_ram #(.WIDTH(LWW), .DEPTH(LEVEL_COUNT)) u_lvl_ram (
    .clk_i   (clk_i),
    .addr_i  (lvl_addr),
    .we_i    (lvl_we),
    .wdata_i (lvl_wdata),
    .rdata_o (lvl_rdata)
  );

  assign s_axis_tready = (state_q == pbts_pkg::ST_IDLE);

  // Sequencer: next state, working registers and RAM accesses.
  always_comb begin
    state_d      = state_q;
    ready_lv_d   = ready_lv_q;
    ready_task_d = ready_task_q;
    idle_d       = idle_q;
    action_d     = action_q;
    t_d          = t_q;
    p_d          = p_q;
    n_d          = n_q;
    tl_d         = tl_q;
    lv_d         = lv_q;
    rlv_d        = rlv_q;
    do_app_d     = do_app_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_task_d   = out_task_q;
    out_idle_d   = out_idle_q;
    out_time_d   = out_time_q;
    task_addr    = t_q[TIW-1:0];
    task_we      = 1'b0;
    task_wdata   = task_rdata;
    lvl_addr     = lv_q;
    lvl_we       = 1'b0;
    lvl_wdata    = lvl_rdata;

    case (state_q)
      pbts_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          action_d = in_action;
          found_d  = 1'b0;
          if (in_action == pbts_pkg::ACT_PICK) begin
            do_app_d = 1'b1;
            lv_d     = top_lv;
            lvl_addr = top_lv;
            state_d  = (ready_lv_q == '0) ? pbts_pkg::ST_OUT : pbts_pkg::ST_PK_H;
          end else if (in_task_ok) begin
            t_d      = IDW'(in_task);
            lv_d     = in_lv_sat;
            do_app_d = (in_action == pbts_pkg::ACT_READY);
            task_addr = TIW'(in_task);
            if (ready_task_q[TIW'(in_task)]) begin
              state_d = pbts_pkg::ST_TK;
            end else if (in_action == pbts_pkg::ACT_READY) begin
              state_d = pbts_pkg::ST_AP;
            end else begin
              state_d = pbts_pkg::ST_OUT;
            end
          end else begin
            state_d = pbts_pkg::ST_OUT;
          end
        end
      end
      pbts_pkg::ST_PK_H: begin
        t_d       = lr_head;
        task_addr = lr_head[TIW-1:0];
        found_d   = 1'b1;
        state_d   = pbts_pkg::ST_TK;
      end
      pbts_pkg::ST_TK: begin
        p_d   = tr_prev;
        n_d   = tr_next;
        rlv_d = tr_lvl;
        if (action_q == pbts_pkg::ACT_PICK && tr_next == NIL) begin
          state_d = pbts_pkg::ST_OUT;
        end else begin
          state_d = pbts_pkg::ST_RM_P;
        end
      end
      // Point the predecessor (or the level head) at the successor.
      pbts_pkg::ST_RM_P: begin
        task_addr = p_q[TIW-1:0];
        lvl_addr  = rlv_q;
        state_d   = pbts_pkg::ST_RM_PW;
      end
      pbts_pkg::ST_RM_PW: begin
        task_addr = p_q[TIW-1:0];
        lvl_addr  = rlv_q;
        if (p_q != NIL) begin
          task_we    = 1'b1;
          task_wdata = {n_q, tr_prev, tr_lvl};
        end else begin
          lvl_we    = 1'b1;
          lvl_wdata = {n_q, lr_tail};
        end
        state_d = pbts_pkg::ST_RM_N;
      end
      // Point the successor (or the level tail) at the predecessor.
      pbts_pkg::ST_RM_N: begin
        task_addr = n_q[TIW-1:0];
        lvl_addr  = rlv_q;
        state_d   = pbts_pkg::ST_RM_NW;
      end
      pbts_pkg::ST_RM_NW: begin
        task_addr = n_q[TIW-1:0];
        lvl_addr  = rlv_q;
        if (n_q != NIL) begin
          task_we    = 1'b1;
          task_wdata = {tr_next, p_q, tr_lvl};
        end else begin
          lvl_we    = 1'b1;
          lvl_wdata = {lr_head, p_q};
        end
        ready_task_d[t_q[TIW-1:0]] = 1'b0;
        if (p_q == NIL && n_q == NIL) begin
          ready_lv_d[rlv_q] = 1'b0;
        end
        state_d = do_app_q ? pbts_pkg::ST_AP : pbts_pkg::ST_OUT;
      end
      // Append at the tail of the target level.
      pbts_pkg::ST_AP: begin
        lvl_addr = lv_q;
        state_d  = pbts_pkg::ST_AP_L;
      end
      pbts_pkg::ST_AP_L: begin
        tl_d      = tl_now;
        lvl_addr  = lv_q;
        lvl_we    = 1'b1;
        lvl_wdata = {(tl_now == NIL) ? t_q : lr_head, t_q};
        task_addr = tl_now[TIW-1:0];
        state_d   = (tl_now == NIL) ? pbts_pkg::ST_AP_T : pbts_pkg::ST_AP_TW;
      end
      pbts_pkg::ST_AP_TW: begin
        task_addr  = tl_q[TIW-1:0];
        task_we    = 1'b1;
        task_wdata = {t_q, tr_prev, tr_lvl};
        state_d    = pbts_pkg::ST_AP_T;
      end
      pbts_pkg::ST_AP_T: begin
        task_addr  = t_q[TIW-1:0];
        task_we    = 1'b1;
        task_wdata = {NIL, tl_q, lv_q};
        ready_lv_d[lv_q] = 1'b1;
        ready_task_d[t_q[TIW-1:0]] = 1'b1;
        state_d    = pbts_pkg::ST_OUT;
      end
      // Load the result and, on a pick, update the idle time.
      pbts_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_task_d  = found_q ? 5'(t_q) : 5'd0;
          out_idle_d  = 1'b0;
          if (action_q == pbts_pkg::ACT_PICK) begin
            if (found_q) begin
              idle_d = '0;
            end else begin
              idle_d     = idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0];
              out_idle_d = 1'b1;
            end
          end
          out_time_d = (action_q == pbts_pkg::ACT_PICK) ?
                       (found_q ? 32'd0 : (idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0])) :
                       idle_q;
          state_d = pbts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pbts_pkg::ST_IDLE;
      ready_lv_q   <= '0;
      ready_task_q <= '0;
      idle_q       <= '0;
      out_valid_q  <= 1'b0;
      tick_q       <= pbts_pkg::TICK_RESET;
    end else begin
      state_q      <= state_d;
      ready_lv_q   <= ready_lv_d;
      ready_task_q <= ready_task_d;
      idle_q       <= idle_d;
      out_valid_q  <= out_valid_d;
      if (psel && penable && pwrite && paddr == 3'd0) begin
        tick_q <= pwdata[pbts_pkg::TICK_W-1:0];
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    t_q        <= t_d;
    p_q        <= p_d;
    n_q        <= n_d;
    tl_q       <= tl_d;
    lv_q       <= lv_d;
    rlv_q      <= rlv_d;
    do_app_q   <= do_app_d;
    found_q    <= found_d;
    out_task_q <= out_task_d;
    out_idle_q <= out_idle_d;
    out_time_q <= out_time_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_time_q, out_idle_q, out_task_q};
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pbts_pkg::REG_TICK) ?
                  32'(tick_q) : 32'd0;

  // An idle result is only given when no level was ready.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbts_pkg::ST_OUT && out_free && action_q == pbts_pkg::ACT_PICK && !found_q)
    |-> (ready_lv_q == '0))
    else $error("idle pick while a level is ready");

  // An idle result never names a task.
  a_idle_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[4:0] == 5'd0))
    else $error("idle result carries a task id");

  // The RAMs are never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbts_pkg::ST_IDLE) |-> !(task_we || lvl_we))
    else $error("RAM write outside a request");

  // An idle pick with no ready level goes straight to the result step.
  a_fast_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && in_action == pbts_pkg::ACT_PICK && ready_lv_q == '0)
    |=> (state_q == pbts_pkg::ST_OUT))
    else $error("idle pick did not finish at once");

endmodule

>>> bench/priority_bitmap_task_scheduler_core_checker.sv
// Result checker for the priority bitmap task scheduler core.
// Watches the request and result channels, predicts each result and compares.
// Depends on pbts_pkg.
`timescale 1ns / 1ps

module priority_bitmap_task_scheduler_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [pbts_pkg::IN_DATA_W-1:0]  req_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [pbts_pkg::OUT_DATA_W-1:0] res_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NTASK = 32;
  localparam logic [5:0] NONE = 6'd32;
  localparam logic [3:0] F_READY = 4'h1;
  localparam logic [3:0] F_CHPRIO = 4'h2;
  localparam logic [3:0] F_WAITOBJ = 4'h4;
  localparam logic [3:0] F_TMO = 4'h8;

  // Packed in result order, lowest bits last.
  typedef struct packed {
    logic [31:0] idle_time;
    logic        idle;
    logic [4:0]  task_id;
  } sched_result_t;

  // Shadow copy of the scheduler state.
  logic [31:0] ready_map;
  logic [5:0]  head_of [32];
  logic [5:0]  tail_of [32];
  logic [5:0]  next_of [NTASK];
  logic [5:0]  prev_of [NTASK];
  logic [4:0]  level_of [NTASK];
  logic [3:0]  flags_of [NTASK];
  logic [31:0] timeout_of [NTASK];
  logic [31:0] idle_ms;
  logic [pbts_pkg::TICK_W-1:0] tick;
  sched_result_t expected_results[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [31:0] map_bit(input logic [4:0] lv);
    return 32'h1 << (5'd31 - lv);
  endfunction

  task automatic unlink(input logic [4:0] t);
    logic [4:0] lv;
    logic [5:0] p;
    logic [5:0] n;
    lv = level_of[t];
    p = prev_of[t];
    n = next_of[t];
    if (p != NONE) next_of[p[4:0]] = n;
    else head_of[lv] = n;
    if (n != NONE) prev_of[n[4:0]] = p;
    else tail_of[lv] = p;
    next_of[t] = NONE;
    prev_of[t] = NONE;
    if (head_of[lv] == NONE) ready_map &= ~map_bit(lv);
  endtask

  task automatic link_tail(input logic [4:0] t, input logic [4:0] lv);
    logic [5:0] tl;
    tl = tail_of[lv];
    prev_of[t] = tl;
    next_of[t] = NONE;
    if (tl != NONE) next_of[tl[4:0]] = {1'b0, t};
    else head_of[lv] = {1'b0, t};
    tail_of[lv] = {1'b0, t};
    level_of[t] = lv;
    ready_map |= map_bit(lv);
  endtask

  // Applies one request to the shadow state and returns its result.
  task automatic schedule_request(input logic [pbts_pkg::IN_DATA_W-1:0] d,
                                  output sched_result_t r);
    pbts_pkg::action_e act;
    logic [4:0] t;
    logic [4:0] lv;
    logic [4:0] base;
    logic [31:0] tmo;
    logic [32:0] sum;
    logic [3:0] st;
    logic [5:0] h;
    bit found;
    act = pbts_pkg::action_e'(d[1:0]);
    t = d[6:2];
    lv = d[11:7];
    base = d[16:12];
    tmo = d[49:18];
    r = '0;
    found = 0;
    if (act == pbts_pkg::ACT_PICK) begin
      for (int l = 0; l < 32; l++) begin
        if (!found && ready_map[31-l] && head_of[l] != NONE) begin
          h = head_of[l];
          found = 1;
          r.task_id = h[4:0];
          if (next_of[h[4:0]] != NONE) begin
            unlink(h[4:0]);
            link_tail(h[4:0], 5'(l));
          end
        end
      end
      if (found) begin
        idle_ms = '0;
      end else begin
        sum = {1'b0, idle_ms} + tick;
        idle_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        r.idle = 1'b1;
      end
    end else begin
      if (flags_of[t] & F_READY) unlink(t);
      flags_of[t] = '0;
      if (act == pbts_pkg::ACT_READY) begin
        link_tail(t, lv);
        flags_of[t] = F_READY | ((lv != base) ? F_CHPRIO : 4'h0);
      end else if (act == pbts_pkg::ACT_BLOCK) begin
        st = d[17] ? F_WAITOBJ : 4'h0;
        if (tmo != 0) begin
          timeout_of[t] = tmo;
          st |= F_TMO;
        end
        flags_of[t] = st;
      end
    end
    r.idle_time = idle_ms;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst_ni) begin
      ready_map = '0;
      idle_ms = '0;
      tick = pbts_pkg::TICK_RESET;
      fails = 0;
      expected_results.delete();
      for (int i = 0; i < 32; i++) begin
        head_of[i] = NONE;
        tail_of[i] = NONE;
        next_of[i] = NONE;
        prev_of[i] = NONE;
        level_of[i] = '0;
        flags_of[i] = '0;
        timeout_of[i] = '0;
      end
    end else begin
      if (psel_i && penable_i && pwrite_i && paddr_i == 3'd0)
        tick = pwdata_i[pbts_pkg::TICK_W-1:0];
      if (req_valid_i && req_ready_i) begin
        schedule_request(req_data_i, want);
        expected_results.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[37:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_data_i[31:0], 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (got.task_id != want.task_id)
            report_mismatch("next_task", 32'(got.task_id), 32'(want.task_id));
          if (got.idle != want.idle)
            report_mismatch("idle_selected", 32'(got.idle), 32'(want.idle));
          if (got.idle_time != want.idle_time)
            report_mismatch("idle_time", got.idle_time, want.idle_time);
          if (res_data_i[39:38] != 2'b00)
            report_mismatch("fill bits", 32'(res_data_i[39:38]), 32'h0);
        end
      end
    end
  end

endmodule

>>> bench/priority_bitmap_task_scheduler_core_test.sv
// Stimulus and verdict for the priority bitmap task scheduler core.
// Drives requests, result back-pressure and tick writes; checking is done
// by priority_bitmap_task_scheduler_core_checker. Depends on pbts_pkg, the core and the checker.
`timescale 1ns / 1ps

module priority_bitmap_task_scheduler_core_test;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [pbts_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [pbts_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  int recv_idle_pct;
  int quiet_cycles;

  priority_bitmap_task_scheduler_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  priority_bitmap_task_scheduler_core_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready),
    .req_data_i(s_axis_tdata),
    .res_valid_i(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_data_i(m_axis_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn at every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [pbts_pkg::IN_DATA_W-1:0] pack_request(
      input pbts_pkg::action_e act, input logic [4:0] t, input logic [4:0] lv,
      input logic [4:0] base, input logic waits, input logic [31:0] tmo);
    return {6'b0, tmo, waits, base, lv, t, act};
  endfunction

  // Offers one request, idling first with the given chance in percent.
  // The valid flag stays up after acceptance until the next idle cycle or drain.
  task automatic send_request(input logic [pbts_pkg::IN_DATA_W-1:0] d, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_tick(input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits for every expected result, then lets the sequencer settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // Random requests: mostly ready and pick traffic on a few hot levels.
  task automatic random_phase(input int count, input int gap_pct);
    pbts_pkg::action_e act;
    logic [4:0] lv;
    logic [31:0] tmo;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: act = pbts_pkg::ACT_PICK;
        4, 5, 6: act = pbts_pkg::ACT_READY;
        7, 8: act = pbts_pkg::ACT_BLOCK;
        default: act = pbts_pkg::ACT_FREE;
      endcase
      lv = ($urandom_range(3) != 0) ? 5'($urandom_range(3)) : 5'($urandom);
      tmo = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
      send_request(pack_request(act, 5'($urandom), lv,
                   ($urandom_range(1) != 0) ? lv : 5'($urandom),
                   1'($urandom), tmo), gap_pct);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    recv_idle_pct = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: idle picks at reset tick, free and block of tasks that are not ready, extremes.
    send_request(pack_request(pbts_pkg::ACT_PICK, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_PICK, 5'd31, 5'd31, 5'd31, 1'b1,
                              32'hFFFF_FFFF), 0);
    send_request(pack_request(pbts_pkg::ACT_FREE, 5'd9, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_BLOCK, 5'd9, 5'd0, 5'd0, 1'b1, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_BLOCK, 5'd10, 5'd0, 5'd0, 1'b0,
                              32'hFFFF_FFFF), 0);
    send_request(pack_request(pbts_pkg::ACT_READY, 5'd0, 5'd31, 5'd31, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_READY, 5'd31, 5'd0, 5'd4, 1'b1,
                              32'hFFFF_FFFF), 0);
    send_request(pack_request(pbts_pkg::ACT_READY, 5'd5, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_READY, 5'd6, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_PICK, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_PICK, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    // Moving a linked task to another level, then freeing the head of a level.
    send_request(pack_request(pbts_pkg::ACT_READY, 5'd5, 5'd7, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_FREE, 5'd6, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_BLOCK, 5'd31, 5'd0, 5'd0, 1'b1, 32'd1), 0);
    send_request(pack_request(pbts_pkg::ACT_FREE, 5'd5, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_PICK, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    send_request(pack_request(pbts_pkg::ACT_FREE, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    drain();

    // A large tick on a run of idle picks, then an all-ones tick write.
    write_tick(32'd1000);
    for (int i = 0; i < 4; i++)
      send_request(pack_request(pbts_pkg::ACT_PICK, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0), 0);
    drain();
    write_tick(32'h0000_FFFF);
    drain();

    // Random traffic in three idling patterns and several tick settings.
    recv_idle_pct = 51;
    random_phase(580, 14);
    drain();
    write_tick(32'd1);
    recv_idle_pct = 14;
    random_phase(580, 51);
    drain();
    write_tick(32'd777);
    recv_idle_pct = 0;
    random_phase(580, 0);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pbts_pkg.sv
sv/pbts_ram.sv
sv/priority_bitmap_task_scheduler_core.sv
bench/priority_bitmap_task_scheduler_core_checker.sv
bench/priority_bitmap_task_scheduler_core_test.sv
